### rtl/core/integer_alu_div_mod_gcd_top_assert.svh
// ----------------------------------------------------------------------------
// Integer ALU assertion macros
// Clocked property wrappers used by the integer ALU top level.
// ----------------------------------------------------------------------------
`ifndef INTEGER_ALU_DIV_MOD_GCD_TOP_ASSERT_SVH
`define INTEGER_ALU_DIV_MOD_GCD_TOP_ASSERT_SVH

// same-cycle implication
`define IALU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ialu assertion failed");

// next-cycle implication
`define IALU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ialu assertion failed");

`endif

### rtl/core/ialu_pkg.sv
// ----------------------------------------------------------------------------
// Integer ALU package
// Field widths, command and error codes, sequencer states.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned OPND_W = 32;
  localparam int unsigned ERR_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_REM = 3'd4,
    CMD_GCD = 3'd5
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 2'd0,
    ERR_DIV_ZERO = 2'd1,
    ERR_RESERVED = 2'd2
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALU,
    ST_ABS_A,
    ST_ABS_B,
    ST_MUL,
    ST_DIV,
    ST_SIGN,
    ST_GCD,
    ST_GSHIFT,
    ST_DONE
  } state_e;

endpackage

### rtl/core/ialu_if.sv
// ----------------------------------------------------------------------------
// Integer ALU channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface ialu_req_if;
  import ialu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [OPND_W-1:0] operand_a;
  logic signed [OPND_W-1:0] operand_b;

  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface ialu_rsp_if;
  import ialu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [OPND_W-1:0] result_value;
  logic [ERR_W-1:0]         error_code;

  modport source (output valid, result_value, error_code, input ready);
  modport sink   (input valid, result_value, error_code, output ready);
endinterface

### rtl/core/integer_alu_div_mod_gcd_top.sv
// ----------------------------------------------------------------------------
// Integer ALU with divide, remainder and gcd
// Sequenced ALU around one shared DATA_WIDTH+1 bit adder/subtractor.
// ----------------------------------------------------------------------------
// One request at a time; the request channel is ready only while the
// sequencer is idle, and a finished result waits in the response register.
// From accept to response valid: add and subtract use one adder step;
// multiply does a shift and conditional add per multiplier bit; divide and
// remainder take the absolute values, run one restoring step per bit, then
// fix the sign; gcd runs binary gcd on the absolute values (one halving,
// subtract or swap per cycle, then one doubling per common factor of two).
// Errors and reserved commands skip straight to the done state.
// The next request is taken in the cycle after the result is loaded, and a
// result that finds the response register still held waits until it drains.
// The single shared adder does one add, subtract or negate per cycle.
// ----------------------------------------------------------------------------
`include "integer_alu_div_mod_gcd_top_assert.svh"

module integer_alu_div_mod_gcd_top #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ialu_req_if.sink   req_i,
  ialu_rsp_if.source rsp_o
);
  import ialu_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned CW = $clog2(DW + 1);

  state_e          state_q, state_d;
  logic [DW-1:0]   x_q, x_d, y_q, y_d, acc_q, acc_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  cmd_e            cmd_q, cmd_d;
  logic            na_q, na_d, nb_q, nb_d;
  err_e            err_q, err_d;

  logic            rsp_valid_q;
  logic [OPND_W-1:0] rsp_res_q;
  err_e            rsp_err_q;
  logic            out_load;

  logic [DW-1:0]   a_dw, b_dw;
  logic [OPND_W-1:0] res_out;

  logic [DW-1:0]   add_a, add_b;
  logic            add_sub;
  logic [DW:0]     add_sum;

  logic [DW-1:0]   shifted;
  logic            req_fire;

  generate
    if (DW <= OPND_W) begin : g_narrow
      assign a_dw    = req_i.operand_a[DW-1:0];
      assign b_dw    = req_i.operand_b[DW-1:0];
      assign res_out = {{(OPND_W - DW){1'b0}}, acc_q};
    end else begin : g_wide
      assign a_dw    = {{(DW - OPND_W){req_i.operand_a[OPND_W-1]}}, req_i.operand_a};
      assign b_dw    = {{(DW - OPND_W){req_i.operand_b[OPND_W-1]}}, req_i.operand_b};
      assign res_out = acc_q[OPND_W-1:0];
    end
  endgenerate

  assign add_sum  = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                  + {{DW{1'b0}}, add_sub};
  assign shifted  = {acc_q[DW-2:0], x_q[DW-1]};
  assign req_fire = req_i.valid && req_i.ready;

  assign req_i.ready        = (state_q == ST_IDLE);
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.result_value = rsp_res_q;
  assign rsp_o.error_code   = rsp_err_q;

  always_comb begin
    state_d  = state_q;
    x_d      = x_q;
    y_d      = y_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    cmd_d    = cmd_q;
    na_d     = na_q;
    nb_d     = nb_q;
    err_d    = err_q;
    add_a    = x_q;
    add_b    = y_q;
    add_sub  = 1'b0;
    out_load = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          x_d   = a_dw;
          y_d   = b_dw;
          na_d  = a_dw[DW-1];
          nb_d  = b_dw[DW-1];
          cmd_d = cmd_e'(req_i.cmd);
          err_d = ERR_OK;
          acc_d = '0;
          cnt_d = CW'(DW);
          unique case (cmd_e'(req_i.cmd))
            CMD_ADD, CMD_SUB: state_d = ST_ALU;
            CMD_MUL:          state_d = ST_MUL;
            CMD_DIV, CMD_REM: begin
              if (b_dw == '0) begin
                err_d   = ERR_DIV_ZERO;
                state_d = ST_DONE;
              end else begin
                state_d = ST_ABS_A;
              end
            end
            CMD_GCD:          state_d = ST_ABS_A;
            default: begin
              err_d   = ERR_RESERVED;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_ALU: begin
        add_sub = (cmd_q == CMD_SUB);
        acc_d   = add_sum[DW-1:0];
        state_d = ST_DONE;
      end
      ST_ABS_A: begin
        add_a   = '0;
        add_b   = x_q;
        add_sub = 1'b1;
        if (na_q) x_d = add_sum[DW-1:0];
        state_d = ST_ABS_B;
      end
      ST_ABS_B: begin
        add_a   = '0;
        add_b   = y_q;
        add_sub = 1'b1;
        if (nb_q) y_d = add_sum[DW-1:0];
        if (cmd_q == CMD_GCD) begin
          cnt_d   = '0;
          state_d = ST_GCD;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_MUL: begin
        add_a = acc_q;
        add_b = x_q;
        if (y_q[0]) acc_d = add_sum[DW-1:0];
        x_d   = {x_q[DW-2:0], 1'b0};
        y_d   = {1'b0, y_q[DW-1:1]};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) state_d = ST_DONE;
      end
      ST_DIV: begin
        add_a   = shifted;
        add_b   = y_q;
        add_sub = 1'b1;
        acc_d   = add_sum[DW] ? add_sum[DW-1:0] : shifted;
        x_d     = {x_q[DW-2:0], add_sum[DW]};
        cnt_d   = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) state_d = ST_SIGN;
      end
      ST_SIGN: begin
        add_a   = '0;
        add_b   = (cmd_q == CMD_DIV) ? x_q : acc_q;
        add_sub = 1'b1;
        if ((cmd_q == CMD_DIV) ? (na_q ^ nb_q) : na_q) begin
          acc_d = add_sum[DW-1:0];
        end else begin
          acc_d = add_b;
        end
        state_d = ST_DONE;
      end
      ST_GCD: begin
        add_sub = 1'b1;
        priority if (x_q == '0) begin
          x_d     = y_q;
          state_d = ST_GSHIFT;
        end else if (y_q == '0) begin
          state_d = ST_GSHIFT;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d   = {1'b0, x_q[DW-1:1]};
          y_d   = {1'b0, y_q[DW-1:1]};
          cnt_d = cnt_q + CW'(1);
        end else if (!x_q[0]) begin
          x_d = {1'b0, x_q[DW-1:1]};
        end else if (!y_q[0]) begin
          y_d = {1'b0, y_q[DW-1:1]};
        end else if (add_sum[DW]) begin
          x_d = add_sum[DW-1:0];
        end else begin
          // swap so the larger value is subtracted from next cycle
          x_d = y_q;
          y_d = x_q;
        end
      end
      ST_GSHIFT: begin
        if (cnt_q == '0) begin
          acc_d   = x_q;
          state_d = ST_DONE;
        end else begin
          x_d   = {x_q[DW-2:0], 1'b0};
          cnt_d = cnt_q - CW'(1);
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
      cnt_q       <= '0;
      cmd_q       <= CMD_ADD;
      err_q       <= ERR_OK;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cmd_q   <= cmd_d;
      err_q   <= err_d;
      if (out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    na_q  <= na_d;
    nb_q  <= nb_d;
    if (out_load) begin
      rsp_res_q <= res_out;
      rsp_err_q <= err_q;
    end
  end

  `IALU_ASSERT_NEXT(a_reserved_err, req_fire && (req_i.cmd > CMD_GCD), (err_q == ERR_RESERVED) && (state_q == ST_DONE))
  `IALU_ASSERT_NEXT(a_div_zero_err, req_fire && ((req_i.cmd == CMD_DIV) || (req_i.cmd == CMD_REM)) && (b_dw == '0), (err_q == ERR_DIV_ZERO) && (state_q == ST_DONE))
  `IALU_ASSERT_NOW(a_err_zero_res, rsp_valid_q && (rsp_err_q != ERR_OK), rsp_res_q == '0)
  `IALU_ASSERT_NOW(a_loop_cnt, (state_q == ST_MUL) || (state_q == ST_DIV), cnt_q != '0)

endmodule
